// ===== sv/mnemonic_index_generator_macros.svh =====
// Assertion helpers for the mnemonic index generator.
`ifndef MNEMONIC_INDEX_GENERATOR_MACROS_SVH
`define MNEMONIC_INDEX_GENERATOR_MACROS_SVH

// Implication checked on every rising clock edge, disabled while in reset.
`define MIG_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("mnemonic_index_generator: check failed");

// Next-cycle implication.
`define MIG_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("mnemonic_index_generator: check failed");

`endif

// ===== sv/mig_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package mig_pkg;
    localparam int MaxEntropyBytesDef = 32;
    localparam int IndexBitsDef       = 11;
    localparam int CsBits             = 4;
    localparam logic [CsBits-1:0] CsMin   = 4'd4;
    localparam logic [CsBits-1:0] CsReset = 4'd8;

    localparam logic [31:0] KInit [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    function automatic logic [31:0] kround(input logic [5:0] t);
        logic [31:0] k [64];
        k = '{
        32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
        32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
        32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
        32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
        32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
        32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
        32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
        32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
        32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
        32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
        32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
        return k[t];
    endfunction

    typedef enum logic [5:0] {
        ST_LOAD  = 6'b000001,
        ST_WFILL = 6'b000010,
        ST_ROUND = 6'b000100,
        ST_EMITR = 6'b001000,
        ST_EMIT  = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    // Control from the sequencer to the hash core.
    typedef struct packed {
        logic       start;    // load initial values
        logic       w_we;     // write schedule word from fill path
        logic [3:0] w_waddr;
        logic [31:0] w_wdata;
    } hash_ctl_t;

    typedef struct packed {
        logic       busy;
        logic       done;     // one-cycle pulse, dig0 valid
        logic [7:0] dig0;
    } hash_sts_t;
endpackage
`default_nettype wire

// ===== sv/mnemonic_index_generator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// After the final entropy byte the block fills the message schedule, runs the
//   SHA-256 rounds, then assembles and emits the indices one by one.
// Entropy is taken one byte per cycle while loading, unless a result waits or cfg_valid
//   is high; a mnemonic has up to 24 words.
//   A waiting result stalls the input; each dropped byte yields one result.
// Reset (aresetn, synchronous, low): checksum_bits=8, nothing loaded, no mnemonic done.
module mnemonic_index_generator
    import mig_pkg::*;
#(
    parameter int MAX_ENTROPY_BYTES = MaxEntropyBytesDef,
    parameter int INDEX_BITS        = IndexBitsDef
)(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CsBits-1:0]     cfg_data,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [7:0]            s_entropy_byte,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [INDEX_BITS-1:0]      m_word_index,
    output logic                       m_last_word,
    output logic                       m_overflow_flag
);
    `include "mnemonic_index_generator_macros.svh"

    localparam int AW = $clog2(MAX_ENTROPY_BYTES);
    localparam int CsMax = MAX_ENTROPY_BYTES / 4;

    // Entropy store: one write port, one registered read port.
    logic [7:0]    ent_mem [MAX_ENTROPY_BYTES];
    logic [7:0]    ent_rd_reg;
    logic [AW-1:0] ent_raddr;
    logic          ent_we;

    state_t          state_reg, state_next;
    logic [CsBits-1:0] checksum_bits_reg;
    logic [CsBits-1:0] cs;
    logic [AW:0]     bytes_loaded_reg, bytes_loaded_next;
    logic [AW:0]     nbytes;
    logic [4:0]      emit_count_reg, emit_count_next;
    logic [4:0]      ms;
    logic [4:0]      fill_reg, fill_next;    // schedule word being filled
    logic [1:0]      sub_reg, sub_next;      // byte within word / index read step
    logic [31:0]     wacc_reg, wacc_next;
    logic [7:0]      dig0_reg;
    logic [8:0]      bitpos_reg, bitpos_next; // first bit of current index
    logic [23:0]     win_reg, win_next;       // bit window for index assembly
    logic            m_valid_reg, m_valid_next;
    logic [INDEX_BITS-1:0] m_idx_reg, m_idx_next;
    logic            m_last_reg, m_last_next;
    logic            m_ovf_reg, m_ovf_next;
    hash_ctl_t       hctl;
    hash_sts_t       hsts;
    logic [5:0]      byte_sel;
    logic [5:0]      wbyte;

    always_comb begin
        cs = checksum_bits_reg;
        if (cs < CsMin) cs = CsMin;
        if (cs > CsBits'(CsMax)) cs = CsBits'(CsMax);
        nbytes = (AW+1)'({cs, 2'b00});
        ms = 5'(cs) * 5'd3;
    end

    assign cfg_ready = (state_reg == ST_LOAD) || (state_reg == ST_DONE);
    assign s_ready = ((state_reg == ST_LOAD) || (state_reg == ST_DONE)) && !m_valid_reg
                     && !cfg_valid;
    assign ent_we = s_valid && s_ready && (state_reg == ST_LOAD);

    always_ff @(posedge aclk) begin
        if (ent_we) begin
            ent_mem[bytes_loaded_reg[AW-1:0]] <= s_entropy_byte;
        end
        ent_rd_reg <= ent_mem[ent_raddr];
    end

    // Byte addressed by fill path or by index assembly.
    assign wbyte = {fill_reg[3:0], sub_reg};
    assign byte_sel = (state_reg == ST_WFILL) ? wbyte : 6'(bitpos_reg[8:3]) + 6'(sub_reg);
    assign ent_raddr = byte_sel[AW-1:0];

    // Byte read last cycle; past the entropy: padding marker, length, checksum digest byte.
    logic [5:0] prev_sel_reg;
    logic [7:0] prev_byte;
    always_ff @(posedge aclk) prev_sel_reg <= byte_sel;
    always_comb begin
        if (prev_sel_reg < 6'(nbytes)) prev_byte = ent_rd_reg;
        else if (state_reg != ST_WFILL) prev_byte = dig0_reg;
        else if (prev_sel_reg == 6'(nbytes)) prev_byte = 8'h80;
        else if (prev_sel_reg == 6'd62) prev_byte = 8'(16'({nbytes, 3'b000}) >> 8);
        else if (prev_sel_reg == 6'd63) prev_byte = 8'({nbytes, 3'b000});
        else prev_byte = 8'h00;
    end

    always_comb begin
        state_next = state_reg;
        bytes_loaded_next = bytes_loaded_reg;
        emit_count_next = emit_count_reg;
        fill_next = fill_reg;
        sub_next = sub_reg;
        wacc_next = wacc_reg;
        bitpos_next = bitpos_reg;
        win_next = win_reg;
        m_valid_next = m_valid_reg;
        m_idx_next = m_idx_reg;
        m_last_next = m_last_reg;
        m_ovf_next = m_ovf_reg;
        hctl = '0;
        if (m_valid_reg && m_ready) m_valid_next = 1'b0;
        unique case (state_reg)
            ST_LOAD: begin
                if (ent_we) begin
                    bytes_loaded_next = bytes_loaded_reg + 1'b1;
                    if (bytes_loaded_reg + 1'b1 >= nbytes) begin
                        state_next = ST_WFILL;
                        fill_next = '0;
                        sub_next = '0;
                    end
                end
            end
            ST_WFILL: begin
                // Read address issued this cycle; data used next cycle.
                if (fill_reg != 5'd0 || sub_reg != 2'd0) begin
                    wacc_next = {wacc_reg[23:0], prev_byte};
                end
                if (sub_reg == 2'd0 && fill_reg != 5'd0) begin
                    hctl.w_we = 1'b1;
                    hctl.w_waddr = 4'(fill_reg - 5'd1);
                    hctl.w_wdata = {wacc_reg[23:0], prev_byte};
                end
                sub_next = sub_reg + 2'd1;
                if (sub_reg == 2'd3) fill_next = fill_reg + 5'd1;
                if (fill_reg == 5'd16) begin
                    hctl.start = 1'b1;
                    state_next = ST_ROUND;
                    sub_next = '0;
                end
            end
            ST_ROUND: begin
                if (hsts.done) begin
                    state_next = ST_EMITR;
                    bitpos_next = '0;
                    emit_count_next = '0;
                    sub_next = '0;
                end
            end
            ST_EMITR: begin
                // Three reads cover the 11-bit window from bitpos.
                if (sub_reg != 2'd0) win_next = {win_reg[15:0], prev_byte};
                sub_next = sub_reg + 2'd1;
                if (sub_reg == 2'd3) begin
                    state_next = ST_EMIT;
                    sub_next = '0;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_idx_next = INDEX_BITS'(win_reg >> (5'd13 - 5'(bitpos_reg[2:0])));
                    m_last_next = (emit_count_reg + 5'd1 == ms);
                    m_ovf_next = 1'b0;
                    emit_count_next = emit_count_reg + 5'd1;
                    bitpos_next = bitpos_reg + 9'(INDEX_BITS);
                    if (emit_count_reg + 5'd1 == ms) begin
                        state_next = ST_DONE;
                        bytes_loaded_next = '0;
                    end else begin
                        state_next = ST_EMITR;
                    end
                end
            end
            ST_DONE: begin
                if (s_valid && s_ready) begin
                    m_valid_next = 1'b1;
                    m_idx_next = '0;
                    m_last_next = 1'b0;
                    m_ovf_next = 1'b1;
                end
            end
            default: state_next = ST_LOAD;
        endcase
        if (cfg_valid && cfg_ready) begin
            state_next = ST_LOAD;
            bytes_loaded_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            checksum_bits_reg <= CsReset;
            bytes_loaded_reg <= '0;
            emit_count_reg <= '0;
            fill_reg <= '0;
            sub_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) checksum_bits_reg <= cfg_data;
            bytes_loaded_reg <= bytes_loaded_next;
            emit_count_reg <= emit_count_next;
            fill_reg <= fill_next;
            sub_reg <= sub_next;
            m_valid_reg <= m_valid_next;
        end
        wacc_reg <= wacc_next;
        bitpos_reg <= bitpos_next;
        win_reg <= win_next;
        m_idx_reg <= m_idx_next;
        m_last_reg <= m_last_next;
        m_ovf_reg <= m_ovf_next;
        if (hsts.done) dig0_reg <= hsts.dig0;
    end

    mig_hash u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (hctl),
        .sts     (hsts)
    );

    assign m_valid = m_valid_reg;
    assign m_word_index = m_idx_reg;
    assign m_last_word = m_last_reg;
    assign m_overflow_flag = m_ovf_reg;

    `MIG_ASSERT_IMPL(a_no_last_ovf, aclk, aresetn, m_valid, !(m_last_word && m_overflow_flag))
    `MIG_ASSERT_IMPL(a_ovf_zero, aclk, aresetn, m_valid && m_overflow_flag, m_word_index == '0)
    `MIG_ASSERT_NEXT(a_last_done, aclk, aresetn,
        m_valid && m_last_word && m_ready && !cfg_valid, state_reg == ST_DONE)
    `MIG_ASSERT_IMPL(a_no_take_busy, aclk, aresetn, state_reg == ST_ROUND, !s_ready)
endmodule
`default_nettype wire

// ===== sv/mig_hash.sv =====
`timescale 1ns / 1ps
`default_nettype none
// SHA-256 compression of one block; schedule words live in a 16 x 32 memory.
// Rounds 0-15 read W[t], then compute.
// Rounds 16-63 read W[t-15], W[t-2], W[t-16], W[t-7], form and store W[t],
// then compute.
module mig_hash
    import mig_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire hash_ctl_t ctl,
    output hash_sts_t      sts
);
    logic [31:0] wmem [16];
    logic [31:0] rdata_reg;
    logic [3:0]  raddr;
    logic        we;
    logic [3:0]  waddr;
    logic [31:0] wdata;

    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg, f_reg, g_reg, h_reg;
    logic [31:0] a_next, b_next, c_next, d_next, e_next, f_next, g_next, h_next;
    logic [6:0]  round_count_reg, round_count_next;
    logic [2:0]  phase_reg, phase_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [31:0] w15_reg, w15_next, w2_reg, w2_next, w16_reg, w16_next, wt_reg, wt_next;
    logic [31:0] wsched, wt, s0w, s1w, s0, s1, ch, maj, t1, t2, h0;
    logic [5:0]  t;
    logic        rnd_go;

    assign t = round_count_reg[5:0];
    // Round fires once its schedule word is ready: in phase 1 for t<16, in phase 5 after.
    assign rnd_go = busy_reg && ((t < 6'd16) ? (phase_reg == 3'd1) : (phase_reg == 3'd5));

    always_ff @(posedge aclk) begin
        if (we) begin
            wmem[waddr] <= wdata;
        end
        rdata_reg <= wmem[raddr];
    end

    // phase 0: W[t-15] (or W[t] for t<16); 1: W[t-2]; 2: W[t-16]; later: W[t-7]
    always_comb begin
        unique case (phase_reg)
            3'd0:    raddr = (t < 6'd16) ? t[3:0] : t[3:0] - 4'd15;
            3'd1:    raddr = t[3:0] - 4'd2;
            3'd2:    raddr = t[3:0];
            default: raddr = t[3:0] - 4'd7;
        endcase
    end

    always_comb begin
        s0w = {w15_reg[6:0], w15_reg[31:7]} ^ {w15_reg[17:0], w15_reg[31:18]}
            ^ (w15_reg >> 3);
        s1w = {w2_reg[16:0], w2_reg[31:17]} ^ {w2_reg[18:0], w2_reg[31:19]}
            ^ (w2_reg >> 10);
        wsched = w16_reg + s0w + rdata_reg + s1w;
        wt  = (t < 6'd16) ? rdata_reg : wt_reg;
        s1  = {e_reg[5:0], e_reg[31:6]} ^ {e_reg[10:0], e_reg[31:11]}
            ^ {e_reg[24:0], e_reg[31:25]};
        ch  = (e_reg & f_reg) ^ (~e_reg & g_reg);
        t1  = h_reg + s1 + ch + kround(t) + wt;
        s0  = {a_reg[1:0], a_reg[31:2]} ^ {a_reg[12:0], a_reg[31:13]}
            ^ {a_reg[21:0], a_reg[31:22]};
        maj = (a_reg & b_reg) ^ (a_reg & c_reg) ^ (b_reg & c_reg);
        t2  = s0 + maj;
        h0  = a_reg + KInit[0];
    end

    always_comb begin
        {a_next, b_next, c_next, d_next} = {a_reg, b_reg, c_reg, d_reg};
        {e_next, f_next, g_next, h_next} = {e_reg, f_reg, g_reg, h_reg};
        round_count_next = round_count_reg;
        phase_next = phase_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        w15_next = w15_reg;
        w2_next = w2_reg;
        w16_next = w16_reg;
        wt_next = wt_reg;
        we = ctl.w_we;
        waddr = ctl.w_waddr;
        wdata = ctl.w_wdata;
        if (ctl.start) begin
            {a_next, b_next, c_next, d_next} = {KInit[0], KInit[1], KInit[2], KInit[3]};
            {e_next, f_next, g_next, h_next} = {KInit[4], KInit[5], KInit[6], KInit[7]};
            round_count_next = '0;
            phase_next = 3'd0;
            busy_next = 1'b1;
        end else if (rnd_go) begin
            h_next = g_reg; g_next = f_reg; f_next = e_reg; e_next = d_reg + t1;
            d_next = c_reg; c_next = b_reg; b_next = a_reg; a_next = t1 + t2;
            round_count_next = round_count_reg + 7'd1;
            phase_next = 3'd0;
            if (t == 6'd63) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (busy_reg) begin
            phase_next = phase_reg + 3'd1;
            unique case (phase_reg)
                3'd1: w15_next = rdata_reg;
                3'd2: w2_next = rdata_reg;
                3'd3: w16_next = rdata_reg;
                3'd4: begin
                    // W[t-7] arrives: form W[t] and store it in place of W[t-16]
                    wt_next = wsched;
                    we = 1'b1;
                    waddr = t[3:0];
                    wdata = wsched;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            round_count_reg <= '0;
            phase_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            round_count_reg <= round_count_next;
            phase_reg <= phase_next;
        end
        {a_reg, b_reg, c_reg, d_reg} <= {a_next, b_next, c_next, d_next};
        {e_reg, f_reg, g_reg, h_reg} <= {e_next, f_next, g_next, h_next};
        w15_reg <= w15_next;
        w2_reg <= w2_next;
        w16_reg <= w16_next;
        wt_reg <= wt_next;
    end

    always_comb begin
        sts.busy = busy_reg;
        sts.done = done_reg;
        sts.dig0 = h0[31:24];
    end
endmodule
`default_nettype wire
